// File: rtl/bfa_pkg.sv
// Shared types and constants for the best-fit block allocator.
// No dependencies; imported by the allocator top level and its checker.
`timescale 1ns / 1ps
package bfa_pkg;

	localparam int REQ_TYPE_W = 1;
	localparam int TAG_W      = 10;
	localparam int BYTES_W    = 11;
	localparam int STATUS_W   = 2;
	localparam int BLK_OUT_W  = 10;

	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC   = 1'b0;
	localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTAG = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LIVE  = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_REC,
		S_SCAN,
		S_SCAN_LAST,
		S_ALLOC_WR,
		S_REL_WR,
		S_RESULT
	} state_t;

endpackage

// File: rtl/bfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the free-space table and the tag record table.
`timescale 1ns / 1ps
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/best_fit_block_allocator.sv
// Best-fit block allocator top level: sequencer, shared compare unit, two RAMs.
// Depends on bfa_pkg and bfa_ram.
//
//   channel | handshake          | fields
//   --------+--------------------+-----------------------------------
//   in      | in_valid/in_stall  | req_type, tag, req_bytes
//   out     | out_valid/out_stall| status, block_index, moved_bytes
//
// An allocate, fitting or not, scans all blocks: the free-space RAM feeds one
// entry per cycle to a single compare unit. A release writes both RAMs; a
// duplicate or unknown tag skips to the result. After reset a clearing pass
// over max(NUM_BLOCKS, NUM_TAGS) entries fills the free-space RAM and clears
// the record live bits with in_stall high. One word is worked on at a time;
// the output register lets a new word enter while a result waits.
`timescale 1ns / 1ps
module best_fit_block_allocator
	import bfa_pkg::*;
#(
	parameter int NUM_BLOCKS     = 1024,
	parameter int BLOCK_CAPACITY = 1024,
	parameter int NUM_TAGS       = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [REQ_TYPE_W-1:0] req_type,
	input  logic [TAG_W-1:0]      tag,
	input  logic [BYTES_W-1:0]    req_bytes,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [BLK_OUT_W-1:0]  block_index,
	output logic [BYTES_W-1:0]    moved_bytes
);

	localparam int BW    = $clog2(NUM_BLOCKS);
	localparam int TW    = $clog2(NUM_TAGS);
	localparam int FW    = $clog2(BLOCK_CAPACITY + 1);
	localparam int CW    = (FW > BYTES_W) ? FW : BYTES_W;
	localparam int MAXD  = (NUM_BLOCKS > NUM_TAGS) ? NUM_BLOCKS : NUM_TAGS;
	localparam int CLRW  = $clog2(MAXD);
	localparam int RECW  = 1 + BW + BYTES_W;

	state_t state_q, state_nxt;

	logic [CLRW-1:0]       clr_q;
	logic [BW-1:0]         scan_q;
	logic                  cmp_v_q;
	logic [BW-1:0]         cmp_idx_q;
	logic                  found_q;
	logic [BW-1:0]         best_q;
	logic [FW-1:0]         best_free_q;
	logic [REQ_TYPE_W-1:0] type_q;
	logic [TAG_W-1:0]      tag_q;
	logic [BYTES_W-1:0]    bytes_q;
	logic [BW-1:0]         rel_blk_q;
	logic [BYTES_W-1:0]    rel_bytes_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [BLK_OUT_W-1:0]  res_blk_q;
	logic [BYTES_W-1:0]    res_bytes_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [BLK_OUT_W-1:0]  block_index_q;
	logic [BYTES_W-1:0]    moved_bytes_q;

	logic            fs_we;
	logic [BW-1:0]   fs_waddr;
	logic [FW-1:0]   fs_wdata;
	logic [BW-1:0]   fs_raddr;
	logic [FW-1:0]   fs_rdata;
	logic            rec_we;
	logic [TW-1:0]   rec_waddr;
	logic [RECW-1:0] rec_wdata;
	logic [TW-1:0]   rec_raddr;
	logic [RECW-1:0] rec_rdata;

	logic                 rec_live;
	logic [BW-1:0]        rec_blk;
	logic [BYTES_W-1:0]   rec_bytes;
	logic                 tag_ok;
	logic                 clr_last;
	logic                 scan_last;
	logic                 fits;
	logic                 better;
	logic                 take;
	logic                 in_acc;
	logic                 out_load;
	logic [CW:0]          rel_sum;

	assign {rec_live, rec_blk, rec_bytes} = rec_rdata;
	assign tag_ok    = 32'(tag_q) < NUM_TAGS;
	assign clr_last  = clr_q == CLRW'(MAXD - 1);
	assign scan_last = scan_q == BW'(NUM_BLOCKS - 1);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_RESULT) && (!out_valid_q || !out_stall);
	assign rel_sum   = (CW + 1)'(fs_rdata) + (CW + 1)'(rel_bytes_q);

	// shared compare unit: fits and strictly smaller than the best so far
	assign fits   = CW'(bytes_q) <= CW'(fs_rdata);
	assign better = !found_q || (fs_rdata < best_free_q);
	assign take   = ((state_q == S_SCAN) || (state_q == S_SCAN_LAST)) &&
	                cmp_v_q && fits && better;

	bfa_ram #(.WIDTH(FW), .DEPTH(NUM_BLOCKS)) u_free_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	bfa_ram #(.WIDTH(RECW), .DEPTH(NUM_TAGS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			type_q  <= req_type;
			tag_q   <= tag;
			bytes_q <= req_bytes;
		end
		if (state_q == S_REC) begin
			scan_q    <= '0;
			cmp_v_q   <= 1'b0;
			found_q   <= 1'b0;
			rel_blk_q <= rec_blk;
			rel_bytes_q <= rec_bytes;
		end
		if (state_q == S_SCAN) begin
			scan_q    <= scan_q + 1'b1;
			cmp_v_q   <= 1'b1;
			cmp_idx_q <= scan_q;
		end
		if (take) begin
			found_q     <= 1'b1;
			best_q      <= cmp_idx_q;
			best_free_q <= fs_rdata;
		end
		unique case (state_q)
			S_REC: begin
				if (!tag_ok) begin
					res_status_q <= (type_q == REQ_ALLOC) ? ST_NOFIT : ST_NOTAG;
				end else if (type_q == REQ_ALLOC) begin
					res_status_q <= ST_LIVE;
				end else begin
					res_status_q <= ST_NOTAG;
				end
				res_blk_q   <= '0;
				res_bytes_q <= '0;
			end
			S_ALLOC_WR: begin
				res_status_q <= found_q ? ST_OK : ST_NOFIT;
				res_blk_q    <= found_q ? BLK_OUT_W'(best_q) : '0;
				res_bytes_q  <= found_q ? bytes_q : '0;
			end
			S_REL_WR: begin
				res_status_q <= ST_OK;
				res_blk_q    <= BLK_OUT_W'(rel_blk_q);
				res_bytes_q  <= rel_bytes_q;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			status_q      <= res_status_q;
			block_index_q <= res_blk_q;
			moved_bytes_q <= res_bytes_q;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall  = state_q != S_IDLE;
		fs_we     = 1'b0;
		fs_waddr  = best_q;
		fs_wdata  = FW'(CW'(best_free_q) - CW'(bytes_q));
		fs_raddr  = scan_q;
		rec_we    = 1'b0;
		rec_waddr = TW'(tag_q);
		rec_wdata = {1'b1, best_q, bytes_q};
		rec_raddr = TW'(tag);
		unique case (state_q)
			S_CLEAR: begin
				fs_we     = 32'(clr_q) < NUM_BLOCKS;
				fs_waddr  = BW'(clr_q);
				fs_wdata  = FW'(BLOCK_CAPACITY);
				rec_we    = 32'(clr_q) < NUM_TAGS;
				rec_waddr = TW'(clr_q);
				rec_wdata = '0;
				if (clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					state_nxt = S_REC;
				end
			end
			S_REC: begin
				// look up the release block now; its free space lands next cycle
				fs_raddr = rec_blk;
				if (!tag_ok) begin
					state_nxt = S_RESULT;
				end else if (type_q == REQ_ALLOC) begin
					state_nxt = rec_live ? S_RESULT : S_SCAN;
				end else begin
					state_nxt = rec_live ? S_REL_WR : S_RESULT;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_nxt = S_SCAN_LAST;
				end
			end
			S_SCAN_LAST: begin
				state_nxt = S_ALLOC_WR;
			end
			S_ALLOC_WR: begin
				fs_we     = found_q;
				rec_we    = found_q;
				state_nxt = S_RESULT;
			end
			S_REL_WR: begin
				fs_we     = 1'b1;
				fs_waddr  = rel_blk_q;
				fs_wdata  = FW'(rel_sum);
				rec_we    = 1'b1;
				rec_wdata = '0;
				state_nxt = S_RESULT;
			end
			S_RESULT: begin
				if (out_load) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign block_index = block_index_q;
	assign moved_bytes = moved_bytes_q;

endmodule

// File: rtl/bfa_checker.sv
// Port-level checks for the best-fit block allocator, bound to the top level.
// Depends on bfa_pkg.
`timescale 1ns / 1ps
module bfa_checker
	import bfa_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [REQ_TYPE_W-1:0] req_type,
	input logic [TAG_W-1:0]      tag,
	input logic [BYTES_W-1:0]    req_bytes,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [STATUS_W-1:0]   status,
	input logic [BLK_OUT_W-1:0]  block_index,
	input logic [BYTES_W-1:0]    moved_bytes
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(block_index) && $stable(moved_bytes))
		else $error("stalled result word changed");

	// one word at a time: stall right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in progress");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> block_index == '0 && moved_bytes == '0)
		else $error("error result carries nonzero fields");

	// a new result only comes from a word that was in progress
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a word in progress");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (.*);

// File: test/best_fit_block_allocator_test.sv
// Self-checking bench for the best-fit block allocator: directed and random requests.
// Depends on bfa_pkg and best_fit_block_allocator; holds its own allocator shadow.
`timescale 1ns / 1ps
module best_fit_block_allocator_test;
	import bfa_pkg::*;

	localparam int NUM_BLOCKS     = 1024;
	localparam int BLOCK_CAPACITY = 1024;
	localparam int NUM_TAGS       = 1024;
	localparam int RANDOM_WORDS   = 556;
	localparam int HOLDOFF_CYCLES = 4000;
	localparam int STALL_LIMIT    = 20000;
	localparam int SETTLE_CYCLES  = 1100;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [BLK_OUT_W-1:0] blk;
		logic [BYTES_W-1:0]   nbytes;
	} alloc_result_t;

	// Shadow of the block and records, plus the queue of results still owed.
	class alloc_book;
		logic [BYTES_W-1:0]   free_bytes [NUM_BLOCKS];
		bit                   live [NUM_TAGS];
		logic [BLK_OUT_W-1:0] owner_blk [NUM_TAGS];
		logic [BYTES_W-1:0]   owner_bytes [NUM_TAGS];
		alloc_result_t        owed [$];
		int                   live_count;
		int                   checked;
		int                   errors;

		function void clear();
			foreach (free_bytes[i]) free_bytes[i] = BYTES_W'(BLOCK_CAPACITY);
			foreach (live[i]) live[i] = 1'b0;
			owed.delete();
			live_count = 0;
			checked = 0;
			errors = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Return some live tag, or -1 when none is live.
		function int any_live_tag();
			int start;
			start = $urandom_range(NUM_TAGS - 1);
			for (int k = 0; k < NUM_TAGS; k++)
				if (live[(start + k) % NUM_TAGS])
					return (start + k) % NUM_TAGS;
			return -1;
		endfunction

		function void note_request(logic [REQ_TYPE_W-1:0] rt, logic [TAG_W-1:0] tg,
				logic [BYTES_W-1:0] nb);
			alloc_result_t r;
			int best;
			r.status = ST_OK;
			r.blk = '0;
			r.nbytes = '0;
			best = -1;
			if (rt == REQ_ALLOC) begin
				if (int'(tg) >= NUM_TAGS) begin
					r.status = ST_NOFIT;
				end else if (live[tg]) begin
					r.status = ST_LIVE;
				end else begin
					// smallest free space that still holds the request, lowest index on ties
					for (int i = 0; i < NUM_BLOCKS; i++)
						if (nb <= free_bytes[i] && (best < 0 || free_bytes[i] < free_bytes[best]))
							best = i;
					if (best < 0) begin
						r.status = ST_NOFIT;
					end else begin
						free_bytes[best] = free_bytes[best] - nb;
						live[tg] = 1'b1;
						live_count++;
						owner_blk[tg] = best[BLK_OUT_W-1:0];
						owner_bytes[tg] = nb;
						r.blk = best[BLK_OUT_W-1:0];
						r.nbytes = nb;
					end
				end
			end else begin
				if (int'(tg) >= NUM_TAGS || !live[tg]) begin
					r.status = ST_NOTAG;
				end else begin
					free_bytes[owner_blk[tg]] = free_bytes[owner_blk[tg]] + owner_bytes[tg];
					live[tg] = 1'b0;
					live_count--;
					r.blk = owner_blk[tg];
					r.nbytes = owner_bytes[tg];
				end
			end
			owed.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [BLK_OUT_W-1:0] blk,
				logic [BYTES_W-1:0] nb);
			alloc_result_t e;
			if (owed.size() == 0) begin
				$error("unexpected result word: status %0d block_index %0d moved_bytes %0d",
					st, blk, nb);
				errors++;
				return;
			end
			e = owed.pop_front();
			checked++;
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (blk !== e.blk) begin
				$error("block_index: expected %0d, got %0d", e.blk, blk);
				errors++;
			end
			if (nb !== e.nbytes) begin
				$error("moved_bytes: expected %0d, got %0d", e.nbytes, nb);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [TAG_W-1:0]      tag;
	logic [BYTES_W-1:0]    req_bytes;
	logic                  out_valid;
	logic                  out_stall;
	logic [STATUS_W-1:0]   status;
	logic [BLK_OUT_W-1:0]  block_index;
	logic [BYTES_W-1:0]    moved_bytes;

	alloc_book book;
	bit        steady;
	bit        held;
	int        hold_left;
	int        quiet_cycles;

	best_fit_block_allocator #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.BLOCK_CAPACITY(BLOCK_CAPACITY),
		.NUM_TAGS(NUM_TAGS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.tag(tag),
		.req_bytes(req_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.block_index(block_index),
		.moved_bytes(moved_bytes)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: check accepted words, stall at random, one long hold-off.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			book.check_result(status, block_index, moved_bytes);
		if (!held && book.checked == 150) begin
			held = 1'b1;
			hold_left = HOLDOFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && $urandom_range(99) < 17;
		end
	end

	// Abort when neither channel moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("best_fit_block_allocator_test: FAIL");
			$finish;
		end
	end

	task automatic send_word(logic [REQ_TYPE_W-1:0] rt, int tg, int nb);
		while (!steady && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		tag <= tg[TAG_W-1:0];
		req_bytes <= nb[BYTES_W-1:0];
		do @(posedge clk); while (in_stall);
		book.note_request(rt, tg[TAG_W-1:0], nb[BYTES_W-1:0]);
	endtask

	// Hold the sender until every owed result has come back.
	task automatic drain();
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed traffic (releases of live tags, allocs on random tags), some broken requests.
	task automatic random_word();
		int roll;
		int lt;
		int nb;
		roll = $urandom_range(99);
		lt = book.any_live_tag();
		if (book.live_count > 200 && roll >= 50)
			roll = 0;
		if (roll < 40 && lt >= 0) begin
			send_word(REQ_RELEASE, lt, $urandom_range(2047));
		end else if (roll < 45) begin
			send_word(REQ_RELEASE, $urandom_range(NUM_TAGS - 1), $urandom_range(2047));
		end else if (roll < 50 && lt >= 0) begin
			send_word(REQ_ALLOC, lt, $urandom_range(1, 200));
		end else begin
			roll = $urandom_range(99);
			if (roll < 60)
				nb = $urandom_range(1, 300);
			else if (roll < 80)
				nb = $urandom_range(BLOCK_CAPACITY);
			else if (roll < 90)
				nb = $urandom_range(1) ? BLOCK_CAPACITY : 0;
			else
				nb = $urandom_range(BLOCK_CAPACITY + 1, 2047);
			send_word(REQ_ALLOC, $urandom_range(NUM_TAGS - 1), nb);
		end
	endtask

	initial begin
		book = new();
		book.clear();
		steady = 1'b0;
		held = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_ALLOC;
		tag <= '0;
		req_bytes <= '0;
		out_stall <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// zero-byte allocate on an untouched array lands on block 0
		send_word(REQ_ALLOC, 0, 0);
		send_word(REQ_ALLOC, 1, BLOCK_CAPACITY);
		send_word(REQ_ALLOC, 2, 0);
		send_word(REQ_ALLOC, 3, 2047);
		send_word(REQ_ALLOC, 4, BLOCK_CAPACITY + 1);
		send_word(REQ_ALLOC, 1, 5);
		send_word(REQ_RELEASE, 900, 0);
		send_word(REQ_RELEASE, 1, 2047);
		send_word(REQ_ALLOC, NUM_TAGS - 1, 1000);
		send_word(REQ_ALLOC, 512, 24);
		send_word(REQ_ALLOC, 513, 25);
		send_word(REQ_ALLOC, 514, 1);
		send_word(REQ_ALLOC, 515, 1000);
		send_word(REQ_ALLOC, 516, 24);
		send_word(REQ_RELEASE, 513, 11'h2AA);
		send_word(REQ_ALLOC, 517, 1023);
		send_word(REQ_RELEASE, 0, 11'h555);
		send_word(REQ_RELEASE, 0, 0);
		send_word(REQ_ALLOC, 341, 11'h555);
		send_word(REQ_ALLOC, 682, 11'h2AA);
		send_word(REQ_RELEASE, NUM_TAGS - 1, 0);
		send_word(REQ_RELEASE, 682, 0);
		send_word(REQ_RELEASE, 515, 0);
		send_word(REQ_RELEASE, 516, 0);
		in_valid <= 1'b0;
		drain();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			steady = n >= 300 && n < 400;
			if (n == 450) begin
				in_valid <= 1'b0;
				drain();
			end
			random_word();
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("best_fit_block_allocator_test: PASS");
		else
			$display("best_fit_block_allocator_test: FAIL");
		$finish;
	end

endmodule
